@@ design/pts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes for the bitmap priority scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  typedef enum logic [3:0] {
    ACT_INSTALL  = 4'd0,
    ACT_DELAY    = 4'd1,
    ACT_BLK_PRIO = 4'd2,
    ACT_UBK_PRIO = 4'd3,
    ACT_BLK_TASK = 4'd4,
    ACT_UBK_TASK = 4'd5,
    ACT_BLK_RNG  = 4'd6,
    ACT_UBK_RNG  = 4'd7,
    ACT_TICK     = 4'd8,
    ACT_SCHED    = 4'd9
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_IRQ    = 2'd1,
    ST_NOTASK = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_WALK,
    S_TOP,
    S_RESCHED,
    S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic read;      // register table reads for the request
    logic exec;      // apply single action
    logic walk_init; // load slot walker
    logic walk_step; // one slot of range or tick walk
    logic top;       // register top-priority search
    logic resched;   // update running task
    logic out_load;  // fill output register
  } pts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;
    logic needs_walk;
  } pts_sts_t;

  localparam logic [15:0] TICK_WRAP_RST = 16'd64000;

endpackage
`default_nettype wire

@@ design/pts_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer: read, execute, optional slot walk, search, reschedule, output.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            out_busy_i,
  output pts_pkg::pts_cmd_t    cmd_o,
  input  wire pts_pkg::pts_sts_t sts_i
);
  import pts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_READ;
      S_READ:    state_d = S_EXEC;
      S_EXEC:    state_d = sts_i.needs_walk ? S_WALK : S_TOP;
      S_WALK:    if (sts_i.walk_done) state_d = S_TOP;
      S_TOP:     state_d = S_RESCHED;
      S_RESCHED: state_d = S_OUT;
      S_OUT:     if (!out_busy_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_READ: cmd_o.read = 1'b1;
      S_EXEC: begin
        cmd_o.exec      = 1'b1;
        cmd_o.walk_init = 1'b1;
      end
      S_WALK:    cmd_o.walk_step = 1'b1;
      S_TOP:     cmd_o.top = 1'b1;
      S_RESCHED: cmd_o.resched = 1'b1;
      S_OUT:     cmd_o.out_load = !out_busy_i;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ design/pts_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pts_dp
// Scheduler state: masks, task tables, wake times, tick counter, walker.
// ----------------------------------------------------------------------------
module pts_dp #(
  parameter int NUM_PRIORITIES = 32,
  parameter int TASK_SLOTS     = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_wdata_i,
  input  wire logic [3:0]        action_i,
  input  wire logic [4:0]        task_index_i,
  input  wire logic [4:0]        priority_req_i,
  input  wire logic [5:0]        task_count_i,
  input  wire logic [15:0]       wait_ticks_i,
  input  wire logic              in_interrupt_i,
  input  wire pts_pkg::pts_cmd_t cmd_i,
  output pts_pkg::pts_sts_t      sts_o,
  output logic [1:0]             status_o,
  output logic [4:0]             next_task_o,
  output logic [4:0]             next_priority_o,
  output logic                   switched_o
);
  import pts_pkg::*;

  localparam logic [31:0] PRIO_MASK = 32'hFFFF_FFFF >> (32 - NUM_PRIORITIES);

  logic [15:0] tick_wrap_q;
  logic [31:0] ready_q, unblk_q;
  logic [31:0] delaying_q;
  logic [15:0] tick_q;
  logic [4:0]  run_q;
  logic [4:0]  tprio_mem [32];
  logic [4:0]  ptask_mem [32];
  logic [15:0] wake_mem [32];

  // captured request
  logic [3:0]  act_q;
  logic [4:0]  tsk_q, prio_q;
  logic [5:0]  cnt_q;
  logic [15:0] wait_q;
  logic        irq_q;
  // registered table reads
  logic [4:0]  pot_task_q, pot_run_q, top_prio_q, top_task_q;
  logic [4:0]  tsk_of_prio_q;
  logic [1:0]  status_q;
  logic        sw_q;
  logic        resched_q;
  logic        refused_q;
  // walker
  logic [5:0]  wi_q;
  logic [5:0]  wend_q;
  logic [4:0]  w_prio_q;
  logic [15:0] w_wake_q;
  logic        w_valid_q;
  logic        w_slot_ok_q;

  function automatic logic [31:0] pbit(input logic [4:0] p);
    if ({27'd0, p} >= NUM_PRIORITIES) return '0;
    return 32'd1 << p;
  endfunction

  logic refusable;
  assign refusable = (act_q == ACT_DELAY) || (act_q == ACT_BLK_PRIO) ||
                     (act_q == ACT_BLK_TASK) || (act_q == ACT_BLK_RNG) ||
                     (act_q == ACT_UBK_RNG);

  logic tsk_ok;
  assign tsk_ok = (tsk_q != 5'd0) && ({27'd0, tsk_q} < TASK_SLOTS);

  logic is_walk;
  assign is_walk = !refused_q && ((act_q == ACT_TICK) || (act_q == ACT_BLK_RNG) ||
                                   (act_q == ACT_UBK_RNG));

  // wake time and tick increment
  logic [16:0] wsum, wsub, tinc;
  assign wsum = {1'b0, tick_q} + {1'b0, wait_q};
  assign wsub = wsum - {1'b0, tick_wrap_q};
  assign tinc = {1'b0, tick_q} + 17'd1;

  // top priority search over the eligible mask
  logic [31:0] elig;
  logic [4:0]  top_p;
  assign elig = ready_q & unblk_q & PRIO_MASK;
  always_comb begin
    top_p = '0;
    for (int i = 0; i < 32; i++) begin
      if (elig[i]) top_p = 5'(i);
    end
  end

  // walk pipeline: stage 0 reads slot wi_q, stage 1 applies it
  logic [5:0] wlim;
  assign wlim = ({1'b0, wend_q} > 7'(TASK_SLOTS)) ? 6'(TASK_SLOTS) : wend_q;
  assign sts_o.needs_walk = is_walk;
  assign sts_o.walk_done  = (wi_q >= wlim) && !w_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_step && (wi_q < wlim)) begin
      w_prio_q    <= ptask_mem[wi_q[4:0]];
      w_wake_q    <= wake_mem[wi_q[4:0]];
      w_slot_ok_q <= (wi_q != 6'd0) && (wi_q[4:0] != run_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_wrap_q <= TICK_WRAP_RST;
      ready_q     <= '0;
      unblk_q     <= '1;
      delaying_q  <= '0;
      tick_q      <= '0;
      run_q       <= '0;
      wi_q        <= '0;
      wend_q      <= '0;
      w_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) tick_wrap_q <= cfg_wdata_i;
      if (cmd_i.walk_init) begin
        w_valid_q <= 1'b0;
        if (act_q == ACT_TICK) begin
          wi_q   <= 6'd1;
          wend_q <= 6'd32;
        end else begin
          wi_q   <= {1'b0, tsk_q};
          wend_q <= (7'({1'b0, tsk_q}) + 7'(cnt_q) > 7'd32) ? 6'd32
                    : 6'({1'b0, tsk_q}) + cnt_q;
        end
      end
      if (cmd_i.exec && !refused_q) begin
        unique case (act_q)
          ACT_INSTALL: if (tsk_ok) begin
            delaying_q[tsk_q] <= 1'b0;
            ready_q <= ready_q | pbit(prio_q);
          end
          ACT_DELAY: if (run_q != 5'd0) begin
            delaying_q[run_q] <= 1'b1;
            ready_q <= ready_q & ~pbit(pot_run_q);
          end
          ACT_BLK_PRIO: unblk_q <= unblk_q & ~pbit(prio_q);
          ACT_UBK_PRIO: unblk_q <= unblk_q | pbit(prio_q);
          ACT_BLK_TASK: if (tsk_ok) unblk_q <= unblk_q & ~pbit(pot_task_q);
          ACT_UBK_TASK: if (tsk_ok) unblk_q <= unblk_q | pbit(pot_task_q);
          ACT_TICK: tick_q <= (tinc >= {1'b0, tick_wrap_q}) ? 16'd0 : tinc[15:0];
          default: ;
        endcase
      end
      if (cmd_i.walk_step) begin
        w_valid_q <= wi_q < wlim;
        if (wi_q < wlim) wi_q <= wi_q + 6'd1;
        if (w_valid_q) begin
          if (act_q == ACT_TICK) begin
            if (delaying_q[wi_q[4:0] - 5'd1] && (w_wake_q == tick_q)) begin
              ready_q <= ready_q | pbit(w_prio_q);
              delaying_q[wi_q[4:0] - 5'd1] <= 1'b0;
            end
          end else if (w_slot_ok_q) begin
            if (act_q == ACT_BLK_RNG) unblk_q <= unblk_q & ~pbit(w_prio_q);
            else unblk_q <= unblk_q | pbit(w_prio_q);
          end
        end
      end
      if (cmd_i.resched && resched_q && (top_task_q != run_q)) run_q <= top_task_q;
    end
  end

  // table memories and request registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      tsk_q  <= task_index_i;
      prio_q <= priority_req_i;
      cnt_q  <= task_count_i;
      wait_q <= wait_ticks_i;
      irq_q  <= in_interrupt_i;
    end
    if (cmd_i.read) begin
      pot_task_q    <= ptask_mem[tsk_q];
      pot_run_q     <= ptask_mem[run_q];
      tsk_of_prio_q <= tprio_mem[prio_q];
      refused_q     <= refusable && irq_q;
    end
    if (cmd_i.exec && !refused_q) begin
      if ((act_q == ACT_INSTALL) && tsk_ok) begin
        tprio_mem[prio_q] <= tsk_q;
        ptask_mem[tsk_q]  <= prio_q;
      end
      if ((act_q == ACT_DELAY) && (run_q != 5'd0)) begin
        wake_mem[run_q] <= (wsum >= {1'b0, tick_wrap_q}) ? wsub[15:0] : wsum[15:0];
      end
    end
    if (cmd_i.exec) begin
      status_q <= ST_OK;
      if (refused_q) status_q <= ST_IRQ;
      else if ((act_q == ACT_DELAY) && (run_q == 5'd0)) status_q <= ST_NOTASK;
      resched_q <= 1'b0;
      if (!refused_q) begin
        case (act_q)
          ACT_DELAY:    resched_q <= run_q != 5'd0;
          ACT_BLK_PRIO: resched_q <= run_q == tsk_of_prio_q;
          ACT_UBK_PRIO: resched_q <= (run_q != 5'd0) && !irq_q;
          ACT_BLK_TASK: resched_q <= tsk_ok && (run_q == tsk_q);
          ACT_UBK_TASK: resched_q <= tsk_ok && (run_q != 5'd0) && !irq_q;
          ACT_TICK, ACT_SCHED: resched_q <= 1'b1;
          default: ;
        endcase
      end
    end
    if (cmd_i.top) begin
      top_prio_q <= top_p;
      top_task_q <= tprio_mem[top_p];
    end
    if (cmd_i.resched) sw_q <= resched_q && (top_task_q != run_q);
    if (cmd_i.out_load) begin
      status_o        <= status_q;
      next_task_o     <= top_task_q;
      next_priority_o <= top_prio_q;
      switched_o      <= sw_q;
    end
  end

endmodule
`default_nettype wire

@@ design/priority_task_scheduler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Bitmap priority-preemptive task scheduler with tick-driven delays.
// ----------------------------------------------------------------------------
// sequence: capture, table read, execute, an optional slot walk for tick and
// range actions, top-priority search, reschedule, then the output load
// flow: one item at a time; the next transfer is taken the cycle after the
// result is loaded, and a stalled output register holds the sequencer
// reset: ready mask, delay flags, tick counter and running task cleared and
// unblock mask set at once; task tables and wake times hold nothing until written
module priority_task_scheduler #(
  parameter int NUM_PRIORITIES = 32,
  parameter int TASK_SLOTS     = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  action_i,
  input  wire logic [4:0]  task_index_i,
  input  wire logic [4:0]  priority_req_i,
  input  wire logic [5:0]  task_count_i,
  input  wire logic [15:0] wait_ticks_i,
  input  wire logic        in_interrupt_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [4:0]       next_task_o,
  output logic [4:0]       next_priority_o,
  output logic             switched_o
);
  import pts_pkg::*;

  pts_cmd_t cmd;
  pts_sts_t sts;
  logic     out_valid_q;

  // output register holds the result until transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end
  assign out_valid_o = out_valid_q;

  pts_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_busy_i(out_valid_q && !out_ready_i),
    .cmd_o(cmd), .sts_i(sts)
  );

  pts_dp #(.NUM_PRIORITIES(NUM_PRIORITIES), .TASK_SLOTS(TASK_SLOTS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .action_i, .task_index_i, .priority_req_i, .task_count_i,
    .wait_ticks_i, .in_interrupt_i,
    .cmd_i(cmd), .sts_o(sts),
    .status_o, .next_task_o, .next_priority_o, .switched_o
  );

endmodule
`default_nettype wire

@@ verif/priority_task_scheduler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler_tb
// Drives kernel actions through the request channel, predicts status and the
// selected task for every transfer, and checks each result in order while
// the tick wrap value is stepped through several settings.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [3:0]  act;
  logic [4:0]  task_idx;
  logic [4:0]  prio;
  logic [5:0]  count;
  logic [15:0] wait_len;
  logic        irq;
} sched_req_t;

class sched_scoreboard;
  typedef struct packed {
    logic [1:0] st;
    logic [4:0] nt;
    logic [4:0] np;
    logic       sw;
  } sched_rsp_t;

  logic [31:0] ready_bits;
  logic [31:0] unblk_bits;
  logic [4:0]  task_at_prio [32];
  logic [4:0]  prio_at_task [32];
  logic [15:0] wake_at [32];
  bit          sleeping [32];
  bit          prio_known [32];
  bit          task_known [32];
  logic [15:0] ticks;
  logic [4:0]  running;
  logic [15:0] wrap;
  sched_rsp_t  pending [$];
  int          errors;

  function new();
    ready_bits = '0;
    unblk_bits = '1;
    ticks      = '0;
    running    = '0;
    wrap       = pts_pkg::TICK_WRAP_RST;
    errors     = 0;
    for (int i = 0; i < 32; i++) begin
      sleeping[i]   = 0;
      prio_known[i] = 0;
      task_known[i] = 0;
    end
  endfunction

  function logic [4:0] top_prio();
    logic [31:0] m;
    logic [4:0]  p;
    m = ready_bits & unblk_bits;
    p = '0;
    for (int i = 0; i < 32; i++) if (m[i]) p = i[4:0];
    return p;
  endfunction

  function bit reselect();
    logic [4:0] t;
    t = task_at_prio[top_prio()];
    if (t != running) begin
      running = t;
      return 1;
    end
    return 0;
  endfunction

  // turn a request that would read a table entry never written into an install
  function sched_req_t legalize(sched_req_t r);
    int last;
    case (r.act)
      pts_pkg::ACT_BLK_PRIO: if (!r.irq && !prio_known[r.prio]) r.act = pts_pkg::ACT_INSTALL;
      pts_pkg::ACT_BLK_TASK, pts_pkg::ACT_UBK_TASK:
        if (r.task_idx != 0 && !task_known[r.task_idx]) r.act = pts_pkg::ACT_INSTALL;
      pts_pkg::ACT_BLK_RNG, pts_pkg::ACT_UBK_RNG: begin
        last = r.task_idx + r.count;
        if (!r.irq)
          for (int i = r.task_idx; i < last && i < 32; i++)
            if (i != 0 && i != running && !task_known[i]) begin
              r.act      = pts_pkg::ACT_INSTALL;
              r.task_idx = i[4:0];
              break;
            end
      end
      default: ;
    endcase
    return r;
  endfunction

  function void note_request(sched_req_t r);
    sched_rsp_t e;
    logic [16:0] w;
    int last;
    e.st = pts_pkg::ST_OK;
    e.sw = 0;
    if (r.irq && (r.act == pts_pkg::ACT_DELAY || r.act == pts_pkg::ACT_BLK_PRIO ||
                  r.act == pts_pkg::ACT_BLK_TASK || r.act == pts_pkg::ACT_BLK_RNG ||
                  r.act == pts_pkg::ACT_UBK_RNG)) begin
      e.st = pts_pkg::ST_IRQ;
    end else begin
      case (r.act)
        pts_pkg::ACT_INSTALL: if (r.task_idx != 0) begin
          task_at_prio[r.prio]     = r.task_idx;
          prio_at_task[r.task_idx] = r.prio;
          prio_known[r.prio]       = 1;
          task_known[r.task_idx]   = 1;
          sleeping[r.task_idx]     = 0;
          ready_bits[r.prio]       = 1'b1;
        end
        pts_pkg::ACT_DELAY: begin
          if (running == 0) begin
            e.st = pts_pkg::ST_NOTASK;
          end else begin
            w = {1'b0, ticks} + r.wait_len;
            if (w >= wrap) w = w - wrap;
            wake_at[running]  = w[15:0];
            sleeping[running] = 1;
            ready_bits[prio_at_task[running]] = 1'b0;
            e.sw = reselect();
          end
        end
        pts_pkg::ACT_BLK_PRIO: begin
          unblk_bits[r.prio] = 1'b0;
          if (running == task_at_prio[r.prio]) e.sw = reselect();
        end
        pts_pkg::ACT_UBK_PRIO: begin
          unblk_bits[r.prio] = 1'b1;
          if (running != 0 && !r.irq) e.sw = reselect();
        end
        pts_pkg::ACT_BLK_TASK: if (r.task_idx != 0) begin
          unblk_bits[prio_at_task[r.task_idx]] = 1'b0;
          if (running == r.task_idx) e.sw = reselect();
        end
        pts_pkg::ACT_UBK_TASK: if (r.task_idx != 0) begin
          unblk_bits[prio_at_task[r.task_idx]] = 1'b1;
          if (running != 0 && !r.irq) e.sw = reselect();
        end
        pts_pkg::ACT_BLK_RNG, pts_pkg::ACT_UBK_RNG: begin
          last = r.task_idx + r.count;
          for (int i = r.task_idx; i < last && i < 32; i++)
            if (i != 0 && i != running)
              unblk_bits[prio_at_task[i]] = (r.act == pts_pkg::ACT_UBK_RNG);
        end
        pts_pkg::ACT_TICK: begin
          if ({1'b0, ticks} + 17'd1 >= {1'b0, wrap}) ticks = '0;
          else ticks = ticks + 16'd1;
          for (int i = 1; i < 32; i++)
            if (sleeping[i] && wake_at[i] == ticks) begin
              ready_bits[prio_at_task[i]] = 1'b1;
              sleeping[i] = 0;
            end
          e.sw = reselect();
        end
        pts_pkg::ACT_SCHED: e.sw = reselect();
        default: ;
      endcase
    end
    e.np = top_prio();
    e.nt = task_at_prio[e.np];
    pending.push_back(e);
  endfunction

  function void check_result(logic [1:0] st, logic [4:0] nt, logic [4:0] np, logic sw);
    sched_rsp_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: st=%0d task=%0d prio=%0d sw=%0d",
                                 st, nt, np, sw);
      return;
    end
    e = pending.pop_front();
    if (st !== e.st || nt !== e.nt || np !== e.np || sw !== e.sw) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp st=%0d task=%0d prio=%0d sw=%0d, got st=%0d task=%0d prio=%0d sw=%0d",
                 e.st, e.nt, e.np, e.sw, st, nt, np, sw);
    end
  endfunction
endclass

module priority_task_scheduler_tb;
  import pts_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 50;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [3:0]  action_i;
  logic [4:0]  task_index_i;
  logic [4:0]  priority_req_i;
  logic [5:0]  task_count_i;
  logic [15:0] wait_ticks_i;
  logic        in_interrupt_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [4:0]  next_task_o;
  logic [4:0]  next_priority_o;
  logic        switched_o;

  sched_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  priority_task_scheduler u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .action_i, .task_index_i, .priority_req_i, .task_count_i, .wait_ticks_i,
    .in_interrupt_i, .out_valid_o, .out_ready_i, .status_o, .next_task_o,
    .next_priority_o, .switched_o
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("priority_task_scheduler test failed");
      $finish;
    end
  end

  // receiver stall pattern rotates through always-ready, random and periodic modes
  always @(posedge clk_i) begin
    case ((cycles / 300) % 3)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(99) >= 40);
      default: out_ready_i <= (cycles % 7) > 2;
    endcase
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(status_o, next_task_o, next_priority_o, switched_o);

  function automatic sched_req_t random_req();
    sched_req_t r;
    int pick;
    pick       = $urandom_range(99);
    r.task_idx = 5'($urandom_range(31));
    r.prio     = 5'($urandom_range(31));
    r.count    = 6'($urandom_range(32));
    r.wait_len = ($urandom_range(4) == 0) ? 16'($urandom_range(65534))
                                          : 16'($urandom_range(12));
    r.irq      = ($urandom_range(6) == 0);
    if (pick < 8)       r.act = ACT_INSTALL;
    else if (pick < 23) r.act = ACT_DELAY;
    else if (pick < 30) r.act = ACT_BLK_PRIO;
    else if (pick < 38) r.act = ACT_UBK_PRIO;
    else if (pick < 45) r.act = ACT_BLK_TASK;
    else if (pick < 52) r.act = ACT_UBK_TASK;
    else if (pick < 57) r.act = ACT_BLK_RNG;
    else if (pick < 62) r.act = ACT_UBK_RNG;
    else if (pick < 90) r.act = ACT_TICK;
    else if (pick < 97) r.act = ACT_SCHED;
    else                r.act = 4'($urandom_range(15, 10));
    return r;
  endfunction

  function automatic sched_req_t mk(logic [3:0] a, int t, int p, int c, int w, bit irq);
    sched_req_t r;
    r.act = a; r.task_idx = 5'(t); r.prio = 5'(p); r.count = 6'(c);
    r.wait_len = 16'(w); r.irq = irq;
    return r;
  endfunction

  // called just after a rising edge; returns just after the transfer edge, or after the idle gap that ends a burst
  task automatic send_req(input sched_req_t r);
    r = sb.legalize(r);
    action_i       <= r.act;
    task_index_i   <= r.task_idx;
    priority_req_i <= r.prio;
    task_count_i   <= r.count;
    wait_ticks_i   <= r.wait_len;
    in_interrupt_i <= r.irq;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
      burst_left = $urandom_range(12);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_wrap(input logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.wrap = v;
    @(posedge clk_i);
  endtask

  logic [15:0] wraps [6] = '{16'd64000, 16'd2, 16'd5, 16'd65535, 16'd40, 16'd3};
  sched_req_t  directed [$];

  initial begin
    rst_ni <= 1'b0; cfg_we_i <= 1'b0; cfg_wdata_i <= '0; in_valid_i <= 1'b0;
    action_i <= '0; task_index_i <= '0; priority_req_i <= '0; task_count_i <= '0;
    wait_ticks_i <= '0; in_interrupt_i <= 1'b0; out_ready_i <= 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // level 0 gets a task first so the idle selection is always defined
    directed = '{
      mk(ACT_INSTALL, 5, 0, 0, 0, 0),      mk(ACT_INSTALL, 0, 7, 0, 0, 0),
      mk(ACT_INSTALL, 31, 31, 0, 0, 1),    mk(ACT_INSTALL, 10, 10, 63, 65535, 0),
      mk(ACT_SCHED, 0, 0, 0, 0, 0),        mk(ACT_DELAY, 31, 0, 0, 3, 1),
      mk(ACT_BLK_PRIO, 0, 31, 0, 0, 0),    mk(ACT_UBK_PRIO, 0, 31, 0, 0, 1),
      mk(ACT_UBK_PRIO, 0, 31, 0, 0, 0),    mk(ACT_BLK_TASK, 31, 0, 0, 0, 0),
      mk(ACT_BLK_TASK, 0, 0, 0, 0, 0),     mk(ACT_UBK_TASK, 31, 0, 0, 0, 1),
      mk(ACT_UBK_TASK, 31, 0, 0, 0, 0),    mk(ACT_BLK_RNG, 5, 0, 32, 0, 0),
      mk(ACT_UBK_RNG, 0, 0, 32, 0, 0),     mk(ACT_BLK_RNG, 1, 0, 4, 0, 1),
      mk(ACT_DELAY, 0, 0, 0, 2, 0),        mk(ACT_TICK, 0, 0, 0, 0, 1),
      mk(ACT_TICK, 0, 0, 0, 0, 0),         mk(ACT_DELAY, 0, 0, 0, 0, 0),
      mk(ACT_DELAY, 0, 0, 0, 65534, 0),    mk(ACT_TICK, 0, 0, 0, 0, 0),
      mk(4'd15, 31, 31, 63, 65535, 1),     mk(4'd10, 0, 0, 0, 0, 0)
    };

    for (int ph = 0; ph < 6; ph++) begin
      write_wrap(wraps[ph]);
      if (ph == 0) foreach (directed[i]) send_req(directed[i]);
      for (int n = 0; n < 170; n++) send_req(random_req());
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("priority_task_scheduler test passed");
    end else begin
      $display("priority_task_scheduler test failed");
    end
    $finish;
  end
endmodule
